// ===== src/mmrc_pkg.sv =====
// Package for the memory map region coalescer: multiboot type codes,
// the result word layout and the shared region and type helpers.
// No dependencies.
package mmrc_pkg;

  // Sizes of the fixed fields
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned PAGES_W    = 52;
  localparam int unsigned KB_W       = 54;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned KB_SHIFT   = 10;

  // Default map capacity
  localparam int unsigned MAX_REGIONS_DEF = 256;

  typedef logic [2:0] mb_type_t;
  typedef logic [3:0] efi_type_t;

  // Multiboot region types
  localparam mb_type_t MB_AVAIL    = 3'd1;
  localparam mb_type_t MB_RESERVED = 3'd2;
  localparam mb_type_t MB_ACPI     = 3'd3;
  localparam mb_type_t MB_NVS      = 3'd4;
  localparam mb_type_t MB_BADRAM   = 3'd5;

  // UEFI type codes that map to something other than reserved
  localparam efi_type_t EFI_LOADER_CODE  = 4'd1;
  localparam efi_type_t EFI_LOADER_DATA  = 4'd2;
  localparam efi_type_t EFI_BS_CODE      = 4'd3;
  localparam efi_type_t EFI_BS_DATA      = 4'd4;
  localparam efi_type_t EFI_CONVENTIONAL = 4'd7;
  localparam efi_type_t EFI_UNUSABLE     = 4'd8;
  localparam efi_type_t EFI_ACPI_RECLAIM = 4'd9;
  localparam efi_type_t EFI_ACPI_NVS     = 4'd10;

  // One result word
  typedef struct packed {
    logic [ADDR_W-1:0] region_start;
    logic [ADDR_W-1:0] region_length;
    mb_type_t          region_type;
    logic [IDX_W-1:0]  region_index;
    logic              map_overflow;
    logic [KB_W-1:0]   mem_lower_kb;
    logic [KB_W-1:0]   mem_upper_kb;
    logic              is_last_region;
  } result_t;

  // UEFI type to multiboot type; unknown and reserved-like codes give reserved
  function automatic mb_type_t map_type(input efi_type_t efi);
    mb_type_t t;
    unique case (efi)
      EFI_LOADER_CODE, EFI_LOADER_DATA, EFI_BS_CODE, EFI_BS_DATA,
      EFI_CONVENTIONAL: t = MB_AVAIL;
      EFI_UNUSABLE:     t = MB_BADRAM;
      EFI_ACPI_RECLAIM: t = MB_ACPI;
      EFI_ACPI_NVS:     t = MB_NVS;
      default:          t = MB_RESERVED;
    endcase
    return t;
  endfunction

  // Build one result word, folding an available region into the trackers
  function automatic result_t make_region(
    input logic [ADDR_W-1:0] start,
    input logic [ADDR_W-1:0] stop,
    input mb_type_t          rtype,
    input logic [KB_W-1:0]   lo_kb,
    input logic [KB_W-1:0]   hi_kb,
    input logic [IDX_W-1:0]  idx,
    input logic              ovf,
    input logic              last
  );
    result_t r;
    logic [KB_W-1:0] s_kb;
    logic [KB_W-1:0] e_kb;
    s_kb = start[ADDR_W-1:KB_SHIFT];
    e_kb = stop[ADDR_W-1:KB_SHIFT];
    r.region_start   = start;
    r.region_length  = stop - start;
    r.region_type    = rtype;
    r.region_index   = idx;
    r.map_overflow   = ovf;
    r.mem_lower_kb   = lo_kb;
    r.mem_upper_kb   = hi_kb;
    r.is_last_region = last;
    if (rtype == MB_AVAIL) begin
      if (s_kb < lo_kb) r.mem_lower_kb = s_kb;
      if (e_kb > hi_kb) r.mem_upper_kb = e_kb;
    end
    return r;
  endfunction

endpackage

// ===== src/memory_map_region_coalescer.sv =====
// A descriptor is held in the input register, then its results are written into the result queue that drives the port.
// Throughput: one descriptor per cycle while the queue has room for two words; a descriptor that yields two regions
// puts two words on the result port, drained from a four-word queue.
// Reset (rst_n low, synchronous): no open region, region count zero,
// lowest available KB all ones, highest zero, result queue empty.
// Merges UEFI descriptors into multiboot regions. Depends on mmrc_pkg.
module memory_map_region_coalescer #(
  parameter int unsigned MAX_REGIONS = mmrc_pkg::MAX_REGIONS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // descriptor channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mmrc_pkg::efi_type_t            in_efi_type,
  input  logic [mmrc_pkg::ADDR_W-1:0]    in_phys_start,
  input  logic [mmrc_pkg::PAGES_W-1:0]   in_page_count,
  input  logic                           in_is_last_descriptor,
  // region channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mmrc_pkg::ADDR_W-1:0]    out_region_start,
  output logic [mmrc_pkg::ADDR_W-1:0]    out_region_length,
  output mmrc_pkg::mb_type_t             out_region_type,
  output logic [mmrc_pkg::IDX_W-1:0]     out_region_index,
  output logic                           out_map_overflow,
  output logic [mmrc_pkg::KB_W-1:0]      out_mem_lower_kb,
  output logic [mmrc_pkg::KB_W-1:0]      out_mem_upper_kb,
  output logic                           out_is_last_region
);
  import mmrc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_REGIONS + 1);
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned QP_W   = $clog2(Q_DEPTH);
  localparam int unsigned QC_W   = $clog2(Q_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);
  localparam logic [CNT_W-1:0] IDX_LAST = CNT_W'(MAX_REGIONS - 1);

  // input register
  logic                 s1_valid_r;
  efi_type_t            s1_type_r;
  logic [ADDR_W-1:0]    s1_start_r;
  logic [PAGES_W-1:0]   s1_pages_r;
  logic                 s1_last_r;

  // open region and trackers
  logic                 open_valid_r, open_valid_nxt;
  mb_type_t             open_type_r, open_type_nxt;
  logic [ADDR_W-1:0]    open_start_r, open_start_nxt;
  logic [ADDR_W-1:0]    open_end_r, open_end_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [KB_W-1:0]      lo_kb_r, lo_kb_nxt;
  logic [KB_W-1:0]      hi_kb_r, hi_kb_nxt;

  // result queue
  result_t              q_mem_r [Q_DEPTH];
  logic [QP_W-1:0]      q_wr_r, q_rd_r;
  logic [QC_W-1:0]      q_cnt_r;

  logic                 in_acc, proc, pop;
  mb_type_t             d_type;
  logic [ADDR_W-1:0]    d_end;
  logic                 brk, emit_a, emit_b;
  logic                 ovf_a, ovf_b;
  logic [CNT_W-1:0]     cnt_a, idx_a, idx_b;
  logic [ADDR_W-1:0]    b_start;
  result_t              res_a, res_b;
  logic [QP_W-1:0]      wr_b;
  logic [1:0]           n_push;

  // handshakes: stage 1 moves on when the queue has room for two words
  assign proc     = s1_valid_r && (q_cnt_r <= QC_W'(Q_DEPTH - 2));
  assign in_stall = s1_valid_r && !proc;
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (q_cnt_r != '0);
  assign pop      = out_valid && !out_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_type_r  <= in_efi_type;
      s1_start_r <= in_phys_start;
      s1_pages_r <= in_page_count;
      s1_last_r  <= in_is_last_descriptor;
    end
  end

  // descriptor decode and region break
  assign d_type = map_type(s1_type_r);
  assign d_end  = s1_start_r + {s1_pages_r, PAGE_SHIFT'(0)};
  assign brk    = !open_valid_r || (open_type_r != d_type) || (open_end_r != s1_start_r);
  assign emit_a = brk && open_valid_r;
  assign emit_b = s1_last_r;

  // first result: the old region closed by a break
  always_comb begin
    ovf_a = (cnt_r >= CNT_MAX);
    idx_a = ovf_a ? IDX_LAST : cnt_r;
    res_a = make_region(open_start_r, open_end_r, open_type_r, lo_kb_r, hi_kb_r,
                        IDX_W'(idx_a), ovf_a, 1'b0);
    cnt_a = (emit_a && !ovf_a) ? cnt_r + 1'b1 : cnt_r;
  end

  // second result: the final region on the last descriptor
  always_comb begin
    b_start = brk ? s1_start_r : open_start_r;
    ovf_b   = (cnt_a >= CNT_MAX);
    idx_b   = ovf_b ? IDX_LAST : cnt_a;
    res_b   = make_region(b_start, d_end, d_type,
                          emit_a ? res_a.mem_lower_kb : lo_kb_r,
                          emit_a ? res_a.mem_upper_kb : hi_kb_r,
                          IDX_W'(idx_b), ovf_b, 1'b1);
  end

  // next open region and trackers
  always_comb begin
    open_valid_nxt = open_valid_r;
    open_type_nxt  = open_type_r;
    open_start_nxt = open_start_r;
    open_end_nxt   = open_end_r;
    cnt_nxt        = cnt_r;
    lo_kb_nxt      = lo_kb_r;
    hi_kb_nxt      = hi_kb_r;
    if (proc) begin
      if (s1_last_r) begin
        // map done: back to the empty state
        open_valid_nxt = 1'b0;
        open_type_nxt  = '0;
        open_start_nxt = '0;
        open_end_nxt   = '0;
        cnt_nxt        = '0;
        lo_kb_nxt      = '1;
        hi_kb_nxt      = '0;
      end else begin
        open_valid_nxt = 1'b1;
        open_end_nxt   = d_end;
        cnt_nxt        = cnt_a;
        if (brk) begin
          open_type_nxt  = d_type;
          open_start_nxt = s1_start_r;
        end
        if (emit_a) begin
          lo_kb_nxt = res_a.mem_lower_kb;
          hi_kb_nxt = res_a.mem_upper_kb;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_valid_r <= 1'b0;
      open_type_r  <= '0;
      open_start_r <= '0;
      open_end_r   <= '0;
      cnt_r        <= '0;
      lo_kb_r      <= '1;
      hi_kb_r      <= '0;
    end else begin
      open_valid_r <= open_valid_nxt;
      open_type_r  <= open_type_nxt;
      open_start_r <= open_start_nxt;
      open_end_r   <= open_end_nxt;
      cnt_r        <= cnt_nxt;
      lo_kb_r      <= lo_kb_nxt;
      hi_kb_r      <= hi_kb_nxt;
    end
  end

  // result queue: up to two words in, one word out per cycle while out_stall is low
  assign wr_b   = emit_a ? q_wr_r + 1'b1 : q_wr_r;
  assign n_push = proc ? {1'b0, emit_a} + {1'b0, emit_b} : 2'd0;

  always_ff @(posedge clk) begin
    if (proc && emit_a) q_mem_r[q_wr_r] <= res_a;
    if (proc && emit_b) q_mem_r[wr_b]   <= res_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_wr_r  <= q_wr_r + QP_W'(n_push);
      q_rd_r  <= q_rd_r + QP_W'(pop);
      q_cnt_r <= q_cnt_r + QC_W'(n_push) - QC_W'(pop);
    end
  end

  // result port
  assign out_region_start   = q_mem_r[q_rd_r].region_start;
  assign out_region_length  = q_mem_r[q_rd_r].region_length;
  assign out_region_type    = q_mem_r[q_rd_r].region_type;
  assign out_region_index   = q_mem_r[q_rd_r].region_index;
  assign out_map_overflow   = q_mem_r[q_rd_r].map_overflow;
  assign out_mem_lower_kb   = q_mem_r[q_rd_r].mem_lower_kb;
  assign out_mem_upper_kb   = q_mem_r[q_rd_r].mem_upper_kb;
  assign out_is_last_region = q_mem_r[q_rd_r].is_last_region;

`ifndef ASSERT_OFF
  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QC_W'(Q_DEPTH))
    else $error("result queue over capacity");

  // region count saturates at capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("region count beyond capacity");

  // last descriptor clears the open region and count
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && s1_last_r) |=> (!open_valid_r && cnt_r == '0))
    else $error("state not cleared after last descriptor");

  // a processed descriptor that is not last leaves an open region
  a_open_after: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && !s1_last_r) |=> open_valid_r)
    else $error("no open region after descriptor");
`endif

endmodule
